// File: design/lmsc_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix scan controller package
// Shared types, constants and the column-to-pin mapping.
// ----------------------------------------------------------------------------
package lmsc_pkg;

	// field widths of the request and result ports
	localparam int ROW_W  = 3;
	localparam int COL_W  = 4;
	localparam int CHAN_W = 8;
	localparam int RGB_W  = 3 * CHAN_W;

	// default geometry of the matrix
	localparam int DEF_NUM_ROWS = 7;
	localparam int DEF_NUM_COLS = 16;

	// entries in the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// selector pin map: columns below the gap sit on C0..C1, the middle run
	// skips C2, the top columns sit on port B from B6 upwards
	localparam logic [COL_W-1:0] PIN_GAP_COL   = 4'd2;
	localparam logic [COL_W-1:0] PIN_PORTB_COL = 4'd12;
	localparam logic [COL_W-1:0] PIN_PORTB_OFS = 4'd6;
	localparam logic             PORT_C        = 1'b0;
	localparam logic             PORT_B        = 1'b1;

	// request codes as they arrive on req_type
	typedef enum logic [2:0] {
		OP_WRITE    = 3'd0,
		OP_SWAP     = 3'd1,
		OP_READ     = 3'd2,
		OP_SLOT     = 3'd3,
		OP_HANDOVER = 3'd4,
		OP_ACQUIRE  = 3'd5,
		OP_FILL     = 3'd6,
		OP_UNKNOWN  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_REFUSED = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OWN_LED  = 2'd0,
		OWN_REQ  = 2'd1,
		OWN_SCAN = 2'd2
	} owner_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COL,
		S_WAIT,
		S_FILL
	} back_state_t;

	// classified request as it travels through the queue
	typedef struct packed {
		op_t              op;
		logic             in_range;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [RGB_W-1:0] rgb;
	} cmd_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// tag of a store read in flight
	typedef struct packed {
		logic             valid;
		logic             col_start;
		logic [ROW_W-1:0] row;
		logic             last;
	} rd_tag_t;

	typedef struct packed {
		logic             port;
		logic [COL_W-1:0] bit_no;
	} pin_t;

	// map a column to its active-low selector pin
	function automatic pin_t col_pin(input logic [COL_W-1:0] c);
		pin_t p;
		if (c < PIN_GAP_COL) begin
			p.port   = PORT_C;
			p.bit_no = c;
		end else if (c < PIN_PORTB_COL) begin
			p.port   = PORT_C;
			p.bit_no = c + 4'd1;
		end else begin
			p.port   = PORT_B;
			p.bit_no = c - PIN_PORTB_OFS;
		end
		return p;
	endfunction

endpackage

// File: design/lmsc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lmsc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/lmsc_front.sv
// ----------------------------------------------------------------------------
// LED matrix scan controller front end
// Accepts requests, classifies them and range-checks the pixel position.
// ----------------------------------------------------------------------------
module lmsc_front
	import lmsc_pkg::*;
#(
	parameter int NUM_ROWS = DEF_NUM_ROWS,
	parameter int NUM_COLS = DEF_NUM_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        req_type,
	input  logic [ROW_W-1:0]  row,
	input  logic [4:0]        col,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	input  q_stat_t           q_stat,
	output logic              push,
	output cmd_t              push_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic accept;

	// hold the request while the queue is full
	assign busy   = valid_s1 && q_stat.full;
	assign accept = start && !busy;
	assign push   = valid_s1 && !q_stat.full;

	// classify the request and check the pixel position
	always_comb begin
		cmd_d.op       = op_t'(req_type);
		cmd_d.in_range = ({1'b0, row} < 4'(NUM_ROWS)) && ({1'b0, col} < 6'(NUM_COLS));
		cmd_d.row      = row;
		cmd_d.col      = col[COL_W-1:0];
		cmd_d.rgb      = {red, green, blue};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign push_cmd = cmd_s1;

endmodule

// File: design/lmsc_queue.sv
// ----------------------------------------------------------------------------
// LED matrix scan controller command queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module lmsc_queue
	import lmsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t q_stat
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == NW'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = slot_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("request pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("request popped from an empty queue");

endmodule

// File: design/lmsc_back.sv
// ----------------------------------------------------------------------------
// LED matrix scan controller back end
// Executes requests against the pixel store, the column scan and pin owner.
// ----------------------------------------------------------------------------
module lmsc_back
	import lmsc_pkg::*;
#(
	parameter int NUM_ROWS = DEF_NUM_ROWS,
	parameter int NUM_COLS = DEF_NUM_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  q_stat_t           q_stat,
	input  cmd_t              q_head,
	output logic              pop,
	output logic              strobe,
	output logic [1:0]        status,
	output logic [ROW_W-1:0]  row_index,
	output logic [COL_W-1:0]  column_index,
	output logic              pin_port,
	output logic [COL_W-1:0]  pin_bit,
	output logic [CHAN_W-1:0] duty_red,
	output logic [CHAN_W-1:0] duty_green,
	output logic [CHAN_W-1:0] duty_blue,
	output logic [1:0]        owner,
	output logic              column_started,
	output logic              last
);

	localparam int RW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int CW    = $clog2(NUM_COLS);
	localparam int AW    = 1 + RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam logic [RW-1:0] LAST_ROW = RW'(NUM_ROWS - 1);
	localparam logic [CW-1:0] LAST_COL = CW'(NUM_COLS - 1);

	back_state_t      state_q, state_d;
	logic [CW-1:0]    col_q, col_d;
	owner_t           owner_q, owner_d;
	logic             front_q, front_d;
	logic             swap_q, swap_d;
	logic [RW-1:0]    row_cnt_q;
	logic [CW-1:0]    col_cnt_q;
	logic [RGB_W-1:0] fill_rgb_q;
	logic [DEPTH-1:0] vld_q;
	rd_tag_t          rd_s1;
	logic             rvld_s1;

	logic             strobe_q;
	status_t          status_q;
	logic [ROW_W-1:0] row_index_q;
	logic             started_q;
	logic             last_q;
	logic [RGB_W-1:0] duty_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [RGB_W-1:0] wdata;
	logic [AW-1:0]    raddr;
	logic [RGB_W-1:0] rdata;
	rd_tag_t          issue;
	logic             emit;
	status_t          emit_status;
	logic             fill_last;
	logic             adv_wrap;
	logic [CW-1:0]    adv_col;
	pin_t             pin;

	// pixel store, both banks; bank bit on top of the address
	lmsc_ram #(
		.WIDTH(RGB_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign fill_last = (row_cnt_q == LAST_ROW) && (col_cnt_q == LAST_COL);
	assign adv_wrap  = (col_q == LAST_COL);
	assign adv_col   = adv_wrap ? '0 : col_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequence each request and drive the store ports
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		we          = 1'b0;
		waddr       = {~front_q, row_cnt_q, col_cnt_q};
		wdata       = fill_rgb_q;
		raddr       = {front_q, row_cnt_q, col_q};
		issue       = '0;
		emit        = 1'b0;
		emit_status = ST_DONE;
		col_d       = col_q;
		owner_d     = owner_q;
		front_d     = front_q;
		swap_d      = swap_q;
		unique case (state_q)
			S_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					unique case (q_head.op)
						OP_WRITE: begin
							emit = 1'b1;
							if (q_head.in_range) begin
								we    = 1'b1;
								waddr = {~front_q, q_head.row[RW-1:0], q_head.col[CW-1:0]};
								wdata = q_head.rgb;
							end else begin
								emit_status = ST_REFUSED;
							end
						end
						OP_SWAP: begin
							emit = 1'b1;
							if (swap_q) begin
								emit_status = ST_REFUSED;
							end else begin
								swap_d = 1'b1;
							end
						end
						OP_READ: begin
							if (q_head.in_range) begin
								raddr      = {front_q, q_head.row[RW-1:0], q_head.col[CW-1:0]};
								issue.valid = 1'b1;
								issue.last  = 1'b1;
								state_d     = S_WAIT;
							end else begin
								emit        = 1'b1;
								emit_status = ST_REFUSED;
							end
						end
						OP_SLOT: begin
							if (owner_q == OWN_SCAN) begin
								emit        = 1'b1;
								emit_status = ST_IGNORED;
							end else begin
								// advance the scan; a pending swap lands on the wrap
								col_d = adv_col;
								if (adv_wrap && swap_q) begin
									front_d = ~front_q;
									swap_d  = 1'b0;
								end
								if (owner_q == OWN_REQ) begin
									owner_d = OWN_SCAN;
									emit    = 1'b1;
								end else begin
									state_d = S_COL;
								end
							end
						end
						OP_HANDOVER: begin
							emit = 1'b1;
							if (owner_q == OWN_LED) begin
								owner_d = OWN_REQ;
							end else begin
								emit_status = ST_IGNORED;
							end
						end
						OP_ACQUIRE: begin
							if (owner_q == OWN_SCAN) begin
								owner_d = OWN_LED;
								state_d = S_COL;
							end else begin
								emit        = 1'b1;
								emit_status = ST_IGNORED;
							end
						end
						OP_FILL: begin
							state_d = S_FILL;
						end
						OP_UNKNOWN: begin
							emit        = 1'b1;
							emit_status = ST_IGNORED;
						end
					endcase
				end
			end
			S_COL: begin
				// read one row of the lit column per cycle
				issue.valid     = 1'b1;
				issue.col_start = 1'b1;
				issue.row       = ROW_W'(row_cnt_q);
				issue.last      = (row_cnt_q == LAST_ROW);
				if (row_cnt_q == LAST_ROW) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_IDLE;
			end
			S_FILL: begin
				// write one back-bank pixel per cycle
				we = 1'b1;
				if (fill_last) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// update scan state, valid bits and the read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			owner_q   <= OWN_LED;
			front_q   <= 1'b0;
			swap_q    <= 1'b0;
			row_cnt_q <= '0;
			col_cnt_q <= '0;
			vld_q     <= '0;
			rd_s1     <= '0;
			strobe_q  <= 1'b0;
		end else begin
			col_q    <= col_d;
			owner_q  <= owner_d;
			front_q  <= front_d;
			swap_q   <= swap_d;
			rd_s1    <= issue;
			strobe_q <= emit || rd_s1.valid;
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (pop) begin
				row_cnt_q <= '0;
				col_cnt_q <= '0;
			end else if (state_q == S_COL) begin
				row_cnt_q <= row_cnt_q + 1'b1;
			end else if (state_q == S_FILL) begin
				if (col_cnt_q == LAST_COL) begin
					col_cnt_q <= '0;
					row_cnt_q <= row_cnt_q + 1'b1;
				end else begin
					col_cnt_q <= col_cnt_q + 1'b1;
				end
			end
		end
	end

	// load the result registers
	always_ff @(posedge clk) begin
		if (issue.valid) begin
			rvld_s1 <= vld_q[raddr];
		end
		if (pop) begin
			fill_rgb_q <= q_head.rgb;
		end
		if (rd_s1.valid) begin
			status_q    <= ST_DONE;
			row_index_q <= rd_s1.row;
			started_q   <= rd_s1.col_start;
			last_q      <= rd_s1.last;
			duty_q      <= rvld_s1 ? rdata : '0;
		end else if (emit) begin
			status_q    <= emit_status;
			row_index_q <= '0;
			started_q   <= 1'b0;
			last_q      <= 1'b1;
			duty_q      <= '0;
		end
	end

	assign pin            = col_pin(COL_W'(col_q));
	assign strobe         = strobe_q;
	assign status         = status_q;
	assign row_index      = row_index_q;
	assign column_index   = COL_W'(col_q);
	assign pin_port       = pin.port;
	assign pin_bit        = pin.bit_no;
	assign duty_red       = duty_q[2*CHAN_W +: CHAN_W];
	assign duty_green     = duty_q[CHAN_W +: CHAN_W];
	assign duty_blue      = duty_q[0 +: CHAN_W];
	assign owner          = owner_q;
	assign column_started = started_q;
	assign last           = last_q;

	a_wait_has_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT) |-> rd_s1.valid)
		else $error("drain state entered without a read in flight");

	a_swap_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(front_q != $past(front_q)) |-> ($past(swap_q) && !swap_q && col_q == '0))
		else $error("bank swap outside a pending swap at column wrap");

	a_start_owned: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && started_q) |-> (owner_q == OWN_LED))
		else $error("column start while LEDs do not own the pins");

endmodule

// File: design/led_matrix_scan_controller_core.sv
// ----------------------------------------------------------------------------
// LED matrix scan controller core
// Column-multiplexed RGB matrix driver with a double-buffered pixel store.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. busy rises
// only while the front stage holds a request and the two-entry queue is full.
// Results leave one per cycle, each marked by strobe for exactly one cycle;
// last marks the final result of a request. The receiver cannot stall them.
// A request passes the front stage register and the queue before the back end
// takes it; every result is registered, and pixel reads and column starts also
// pass the registered store read port. The back end sets the rate and takes the
// next request from the queue only when idle again: a column start makes one
// store read per row, and a fill writes one back-bank pixel per cycle after the
// cycle that takes the request from the queue.
// At reset both banks read as zero through per-entry valid bits, bank 0 is
// shown, no swap is pending, column 0 is selected and the LEDs own the pins.
// A swap request waits for the column counter to wrap before banks change.
// ----------------------------------------------------------------------------
module led_matrix_scan_controller_core
	import lmsc_pkg::*;
#(
	parameter int NUM_ROWS = DEF_NUM_ROWS,
	parameter int NUM_COLS = DEF_NUM_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        req_type,
	input  logic [ROW_W-1:0]  row,
	input  logic [4:0]        col,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output logic              strobe,
	output logic [1:0]        status,
	output logic [ROW_W-1:0]  row_index,
	output logic [COL_W-1:0]  column_index,
	output logic              pin_port,
	output logic [COL_W-1:0]  pin_bit,
	output logic [CHAN_W-1:0] duty_red,
	output logic [CHAN_W-1:0] duty_green,
	output logic [CHAN_W-1:0] duty_blue,
	output logic [1:0]        owner,
	output logic              column_started,
	output logic              last
);

	q_stat_t q_stat;
	logic    push;
	cmd_t    push_cmd;
	logic    pop;
	cmd_t    head;

	// classify incoming requests
	lmsc_front #(
		.NUM_ROWS(NUM_ROWS),
		.NUM_COLS(NUM_COLS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req_type(req_type),
		.row     (row),
		.col     (col),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.q_stat  (q_stat),
		.push    (push),
		.push_cmd(push_cmd)
	);

	// decouple front and back
	lmsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.q_stat  (q_stat)
	);

	// execute requests and emit results
	lmsc_back #(
		.NUM_ROWS(NUM_ROWS),
		.NUM_COLS(NUM_COLS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.q_head        (head),
		.pop           (pop),
		.strobe        (strobe),
		.status        (status),
		.row_index     (row_index),
		.column_index  (column_index),
		.pin_port      (pin_port),
		.pin_bit       (pin_bit),
		.duty_red      (duty_red),
		.duty_green    (duty_green),
		.duty_blue     (duty_blue),
		.owner         (owner),
		.column_started(column_started),
		.last          (last)
	);

endmodule

// File: sim/tb_led_matrix_scan_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan controller core testbench
// Drives pixel, swap, fill, slot and pin-sharing requests through the start/busy
// handshake, predicts every strobed result from a behavioural copy of the
// double-buffered store and checks each one in order of arrival.
// ----------------------------------------------------------------------------
module tb_led_matrix_scan_controller_core;
	import lmsc_pkg::*;

	localparam int ROWS = DEF_NUM_ROWS;
	localparam int COLS = DEF_NUM_COLS;

	// one strobed result as seen on the ports
	typedef struct packed {
		status_t           status;
		logic [ROW_W-1:0]  row_index;
		logic [COL_W-1:0]  column_index;
		logic              pin_port;
		logic [COL_W-1:0]  pin_bit;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		owner_t            owner;
		logic              started;
		logic              last_flag;
	} scan_result_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        req_type;
	logic [ROW_W-1:0]  row;
	logic [4:0]        col;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic              strobe;
	logic [1:0]        status;
	logic [ROW_W-1:0]  row_index;
	logic [COL_W-1:0]  column_index;
	logic              pin_port;
	logic [COL_W-1:0]  pin_bit;
	logic [CHAN_W-1:0] duty_red;
	logic [CHAN_W-1:0] duty_green;
	logic [CHAN_W-1:0] duty_blue;
	logic [1:0]        owner;
	logic              column_started;
	logic              last;

	// predicted state of the block
	logic [RGB_W-1:0]  pixels [2][ROWS][COLS];
	logic              shown_bank;
	logic              swap_waiting;
	logic [COL_W-1:0]  lit_column;
	owner_t            pin_holder;

	scan_result_t      awaited_results [$];
	int                fail_count;
	bit                idling_on;

	led_matrix_scan_controller_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.row            (row),
		.col            (col),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.strobe         (strobe),
		.status         (status),
		.row_index      (row_index),
		.column_index   (column_index),
		.pin_port       (pin_port),
		.pin_bit        (pin_bit),
		.duty_red       (duty_red),
		.duty_green     (duty_green),
		.duty_blue      (duty_blue),
		.owner          (owner),
		.column_started (column_started),
		.last           (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// queue one expected result for the column now lit
	task automatic push_result(input status_t st, input logic [ROW_W-1:0] ri,
			input logic [RGB_W-1:0] rgb, input logic started, input logic lst);
		scan_result_t res;
		res.status       = st;
		res.row_index    = ri;
		res.column_index = lit_column;
		// columns 0..1 on C0..C1, 2..11 skip C2, 12..15 on B6..B9
		if (lit_column < 4'd2) begin
			res.pin_port = PORT_C;
			res.pin_bit  = lit_column;
		end else if (lit_column < 4'd12) begin
			res.pin_port = PORT_C;
			res.pin_bit  = lit_column + 4'd1;
		end else begin
			res.pin_port = PORT_B;
			res.pin_bit  = lit_column - 4'd6;
		end
		res.red       = rgb[23:16];
		res.green     = rgb[15:8];
		res.blue      = rgb[7:0];
		res.owner     = pin_holder;
		res.started   = started;
		res.last_flag = lst;
		awaited_results.push_back(res);
	endtask

	// emit one duty result per row of the shown bank
	task automatic light_column();
		for (int r = 0; r < ROWS; r++)
			push_result(ST_DONE, r[ROW_W-1:0], pixels[shown_bank][r][lit_column], 1'b1,
				r == ROWS - 1);
	endtask

	// step to the next column, swapping banks on wrap when a swap waits
	task automatic step_column();
		if (lit_column == COLS - 1) begin
			lit_column = '0;
			if (swap_waiting) begin
				shown_bank   = ~shown_bank;
				swap_waiting = 1'b0;
			end
		end else begin
			lit_column = lit_column + 4'd1;
		end
	endtask

	// update the predicted state for one accepted request and queue its results
	task automatic apply_request(input op_t op, input logic [ROW_W-1:0] r,
			input logic [4:0] c, input logic [RGB_W-1:0] rgb);
		logic in_range;
		logic back;
		in_range = (r < ROWS) && (c < COLS);
		back     = ~shown_bank;
		case (op)
			OP_WRITE: begin
				if (in_range) begin
					pixels[back][r][c[COL_W-1:0]] = rgb;
					push_result(ST_DONE, '0, '0, 1'b0, 1'b1);
				end else begin
					push_result(ST_REFUSED, '0, '0, 1'b0, 1'b1);
				end
			end
			OP_SWAP: begin
				if (swap_waiting) begin
					push_result(ST_REFUSED, '0, '0, 1'b0, 1'b1);
				end else begin
					swap_waiting = 1'b1;
					push_result(ST_DONE, '0, '0, 1'b0, 1'b1);
				end
			end
			OP_READ: begin
				if (in_range)
					push_result(ST_DONE, '0, pixels[shown_bank][r][c[COL_W-1:0]], 1'b0, 1'b1);
				else
					push_result(ST_REFUSED, '0, '0, 1'b0, 1'b1);
			end
			OP_SLOT: begin
				if (pin_holder == OWN_LED) begin
					step_column();
					light_column();
				end else if (pin_holder == OWN_REQ) begin
					step_column();
					pin_holder = OWN_SCAN;
					push_result(ST_DONE, '0, '0, 1'b0, 1'b1);
				end else begin
					push_result(ST_IGNORED, '0, '0, 1'b0, 1'b1);
				end
			end
			OP_HANDOVER: begin
				if (pin_holder == OWN_LED) begin
					pin_holder = OWN_REQ;
					push_result(ST_DONE, '0, '0, 1'b0, 1'b1);
				end else begin
					push_result(ST_IGNORED, '0, '0, 1'b0, 1'b1);
				end
			end
			OP_ACQUIRE: begin
				if (pin_holder == OWN_SCAN) begin
					pin_holder = OWN_LED;
					light_column();
				end else begin
					push_result(ST_IGNORED, '0, '0, 1'b0, 1'b1);
				end
			end
			OP_FILL: begin
				for (int y = 0; y < ROWS; y++)
					for (int x = 0; x < COLS; x++)
						pixels[back][y][x] = rgb;
				push_result(ST_DONE, '0, '0, 1'b0, 1'b1);
			end
			default: push_result(ST_IGNORED, '0, '0, 1'b0, 1'b1);
		endcase
	endtask

	// present one request from a falling edge until it is taken
	task automatic send_request(input op_t op, input logic [ROW_W-1:0] r,
			input logic [4:0] c, input logic [RGB_W-1:0] rgb);
		int gap;
		start    = 1'b1;
		req_type = op;
		row      = r;
		col      = c;
		red      = rgb[23:16];
		green    = rgb[15:8];
		blue     = rgb[7:0];
		do @(posedge clk); while (busy);
		apply_request(op, r, c, rgb);
		@(negedge clk);
		// drop start for a short burst now and then
		if (idling_on && $urandom_range(0, 2) == 0) begin
			gap   = $urandom_range(1, 6);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// weighted random request, mostly well-formed, some out of range
	task automatic random_request();
		int               pick;
		op_t              op;
		logic [ROW_W-1:0] r;
		logic [4:0]       c;
		logic [RGB_W-1:0] rgb;
		pick = $urandom_range(0, 99);
		if (pick < 24)
			op = OP_WRITE;
		else if (pick < 40)
			op = OP_READ;
		else if (pick < 70)
			op = OP_SLOT;
		else if (pick < 78)
			op = OP_SWAP;
		else if (pick < 85)
			op = OP_HANDOVER;
		else if (pick < 92)
			op = OP_ACQUIRE;
		else if (pick < 96)
			op = OP_FILL;
		else if (pick < 98)
			op = OP_UNKNOWN;
		else
			op = op_t'($urandom_range(0, 7));
		r = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, ROWS - 1));
		c = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(COLS, 31))
			: 5'($urandom_range(0, COLS - 1));
		case ($urandom_range(0, 7))
			0:       rgb = '0;
			1:       rgb = '1;
			default: rgb = 24'($urandom());
		endcase
		send_request(op, r, c, rgb);
	endtask

	// extremes of position and colour, refused and empty reads
	task automatic test_pixel_access();
		send_request(OP_READ, 3'd0, 5'd0, '0);
		send_request(OP_WRITE, 3'd0, 5'd0, 24'hFFFFFF);
		send_request(OP_WRITE, 3'd6, 5'd15, 24'hA55AC3);
		send_request(OP_WRITE, 3'd7, 5'd3, 24'h123456);
		send_request(OP_WRITE, 3'd2, 5'd16, 24'h654321);
		send_request(OP_WRITE, 3'd7, 5'd31, 24'hFFFFFF);
		send_request(OP_READ, 3'd7, 5'd0, '0);
		send_request(OP_READ, 3'd0, 5'd31, '0);
		send_request(OP_READ, 3'd6, 5'd15, '0);
	endtask

	// swap latch, refused second swap, fill, column start and a bad code
	task automatic test_bank_swap();
		send_request(OP_SWAP, 3'd0, 5'd0, '0);
		send_request(OP_SWAP, 3'd0, 5'd0, '0);
		send_request(OP_FILL, 3'd0, 5'd0, 24'h123456);
		send_request(OP_SLOT, 3'd0, 5'd0, '0);
		send_request(OP_UNKNOWN, 3'd5, 5'd9, 24'h00FF00);
	endtask

	// hand the pins to key scanning and take them back
	task automatic test_pin_sharing();
		send_request(OP_HANDOVER, 3'd0, 5'd0, '0);
		send_request(OP_HANDOVER, 3'd0, 5'd0, '0);
		send_request(OP_ACQUIRE, 3'd0, 5'd0, '0);
		send_request(OP_SLOT, 3'd0, 5'd0, '0);
		send_request(OP_SLOT, 3'd0, 5'd0, '0);
		send_request(OP_HANDOVER, 3'd0, 5'd0, '0);
		send_request(OP_ACQUIRE, 3'd0, 5'd0, '0);
		send_request(OP_READ, 3'd0, 5'd0, '0);
	endtask

	// random traffic with sender gaps
	task automatic test_random_traffic();
		idling_on = 1'b1;
		repeat (360) random_request();
	endtask

	// random traffic with start held high throughout
	task automatic test_back_to_back();
		idling_on = 1'b0;
		repeat (60) random_request();
	endtask

	// compare each strobed result with the oldest prediction
	always @(posedge clk) begin : check_results
		scan_result_t seen;
		scan_result_t want;
		if (arst_n && strobe) begin
			seen.status       = status_t'(status);
			seen.row_index    = row_index;
			seen.column_index = column_index;
			seen.pin_port     = pin_port;
			seen.pin_bit      = pin_bit;
			seen.red          = duty_red;
			seen.green        = duty_green;
			seen.blue         = duty_blue;
			seen.owner        = owner_t'(owner);
			seen.started      = column_started;
			seen.last_flag    = last;
			if (awaited_results.size() == 0) begin
				if (fail_count < 10)
					$display("%0t unexpected result st=%0d col=%0d", $realtime,
						status, column_index);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (seen !== want) begin
					if (fail_count < 10) begin
						$display("%0t mismatch exp st=%0d ri=%0d col=%0d pin=%0d/%0d",
							$realtime, want.status, want.row_index, want.column_index,
							want.pin_port, want.pin_bit);
						$display("    exp rgb=%02h%02h%02h own=%0d cs=%0b last=%0b",
							want.red, want.green, want.blue, want.owner, want.started,
							want.last_flag);
						$display("    act st=%0d ri=%0d col=%0d pin=%0d/%0d", seen.status,
							seen.row_index, seen.column_index, seen.pin_port, seen.pin_bit);
						$display("    act rgb=%02h%02h%02h own=%0d cs=%0b last=%0b",
							seen.red, seen.green, seen.blue, seen.owner, seen.started,
							seen.last_flag);
					end
					fail_count++;
				end
			end
		end
	end

	// hold reset, run the tests, drain and report
	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		req_type  = OP_WRITE;
		row       = '0;
		col       = '0;
		red       = '0;
		green     = '0;
		blue      = '0;
		idling_on = 1'b1;
		fail_count   = 0;
		shown_bank   = 1'b0;
		swap_waiting = 1'b0;
		lit_column   = '0;
		pin_holder   = OWN_LED;
		for (int b = 0; b < 2; b++)
			for (int y = 0; y < ROWS; y++)
				for (int x = 0; x < COLS; x++)
					pixels[b][y][x] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_pixel_access();
		test_bank_swap();
		test_pin_sharing();
		test_random_traffic();
		test_back_to_back();
		start = 1'b0;

		// drain outstanding results, then watch for strays
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (2 * ROWS + 8) @(posedge clk);

		if (fail_count == 0 && awaited_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
design/lmsc_pkg.sv
design/lmsc_ram.sv
design/lmsc_front.sv
design/lmsc_queue.sv
design/lmsc_back.sv
design/led_matrix_scan_controller_core.sv
sim/tb_led_matrix_scan_controller_core.sv
